@@ hw/rtl/gicdf_pkg.sv @@
// ----------------------------------------------------------------------------
// gicdf_pkg
// Shared types, widths and the normal CDF table for the Gaussian sampler.
// ----------------------------------------------------------------------------
package gicdf_pkg;

    localparam int ROM_DEPTH = 63;
    localparam int ADDR_W    = 6;
    localparam int CDF_W     = 17;
    localparam int XQ_W      = 17;
    localparam int P_W       = 18;
    localparam int STD_W     = 32;
    localparam int MEAN_W    = 32;
    localparam int DEN_W     = 21;
    localparam int DVS_W     = 22;
    localparam int MAG_W     = 50;
    localparam int DVD_W     = 52;
    localparam int Q_W       = 35;
    localparam int SUM_W     = 37;

    localparam logic [ADDR_W-1:0] ROM_LAST = 6'd62;
    localparam logic [ADDR_W-1:0] Z_MID    = 6'd31;
    localparam logic [CDF_W-1:0]  CDF_TOP  = 17'd65536;
    localparam logic [CDF_W-1:0]  CDF_BOT  = 17'd0;

    localparam logic [CDF_W-1:0] CDF_ROM [ROM_DEPTH] = '{
        17'd0,     17'd85,    17'd125,   17'd170,   17'd229,
        17'd308,   17'd406,   17'd537,   17'd701,   17'd911,
        17'd1173,  17'd1494,  17'd1881,  17'd2353,  17'd2923,
        17'd3591,  17'd4378,  17'd5295,  17'd6344,  17'd7543,
        17'd8893,  17'd10401, 17'd12065, 17'd13887, 17'd15860,
        17'd17976, 17'd20218, 17'd22584, 17'd25041, 17'd27571,
        17'd30160, 17'd32768, 17'd35376, 17'd37965, 17'd40495,
        17'd42952, 17'd45318, 17'd47560, 17'd49676, 17'd51649,
        17'd53471, 17'd55135, 17'd56643, 17'd57993, 17'd59192,
        17'd60241, 17'd61158, 17'd61945, 17'd62613, 17'd63183,
        17'd63655, 17'd64042, 17'd64363, 17'd64625, 17'd64835,
        17'd64999, 17'd65130, 17'd65228, 17'd65307, 17'd65366,
        17'd65411, 17'd65451, 17'd65536
    };

    typedef enum logic {
        REG_MEAN = 1'b0,
        REG_STD  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic ready;
        logic done;
    } srch_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [CDF_W-1:0] cdf_value(input logic [ADDR_W-1:0] idx);
        logic [CDF_W-1:0] val;
        if (idx <= ROM_LAST)
        begin
            val = CDF_ROM[idx];
        end
        else
        begin
            val = CDF_TOP;
        end
        return val;
    endfunction

endpackage

@@ hw/rtl/gicdf_in_if.sv @@
// ----------------------------------------------------------------------------
// gicdf_in_if
// Request channel carrying one uniform sample.
// ----------------------------------------------------------------------------
interface gicdf_in_if #(
    parameter int UNIFORM_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic [UNIFORM_BITS-1:0] uniform_sample;

    modport source (output valid, output uniform_sample, input ready);
    modport sink   (input valid, input uniform_sample, output ready);
endinterface

@@ hw/rtl/gicdf_out_if.sv @@
// ----------------------------------------------------------------------------
// gicdf_out_if
// Result channel carrying one normal deviate and its saturation flag.
// ----------------------------------------------------------------------------
interface gicdf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] normal_sample;
    logic        clipped;

    modport source (output valid, output normal_sample, output clipped, input ready);
    modport sink   (input valid, input normal_sample, input clipped, output ready);
endinterface

@@ hw/rtl/gaussian_inverse_cdf_sampler_top.sv @@
// ----------------------------------------------------------------------------
// gaussian_inverse_cdf_sampler_top
// Inverse-transform Gaussian sampler: table search, interpolation, scaling.
// ----------------------------------------------------------------------------
// Flow: each request passes through the scaling folds, 5 or 6 table probes, setup,
//   the iterative divide and a final sum.
// Requests: one at a time; the next is taken once the result is in the output
//   register, so a result waiting there overlaps the next request's work.
// Reset: registers return to mean 0 and std_dev 1.0; the CDF RAM is loaded
//   after reset, during which no request is accepted.
// ----------------------------------------------------------------------------
module gaussian_inverse_cdf_sampler_top #(
    parameter int UNIFORM_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    gicdf_in_if.sink           uniform_ch,
    gicdf_out_if.source        normal_ch
);

    localparam int T_W = UNIFORM_BITS + 17;
    localparam logic [T_W-1:0] FULL = (T_W'(1) << UNIFORM_BITS) - T_W'(1);
    localparam logic [T_W-1:0] HALF = (T_W'(1) << (UNIFORM_BITS - 1)) - T_W'(1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FOLD   = 7'b0000010,
        S_SRCH   = 7'b0000100,
        S_MUL    = 7'b0001000,
        S_DSTART = 7'b0010000,
        S_DWAIT  = 7'b0100000,
        S_SUM    = 7'b1000000
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    logic [gicdf_pkg::MEAN_W-1:0]     mean_reg;
    logic [gicdf_pkg::STD_W-1:0]      std_reg;
    logic [T_W-1:0]                   t_reg;
    logic [gicdf_pkg::XQ_W-1:0]       q_reg;
    logic [gicdf_pkg::XQ_W-1:0]       xq_reg;
    logic [gicdf_pkg::CDF_W-1:0]      w_reg;
    logic [gicdf_pkg::P_W-1:0]        p_reg;
    logic                             neg_reg;
    logic [gicdf_pkg::MAG_W-1:0]      mag_reg;
    logic                             out_valid_reg;
    logic [31:0]                      out_data_reg;
    logic                             out_clip_reg;

    logic                             accept;
    logic                             wr_en;
    logic [T_W-1:0]                   t_hi;
    logic [T_W-1:0]                   t_lo;
    logic [gicdf_pkg::XQ_W-1:0]       xq_next;
    logic                             srch_start;
    gicdf_pkg::srch_stat_t            srch_stat;
    logic [gicdf_pkg::ADDR_W-1:0]     srch_lo;
    logic [gicdf_pkg::CDF_W-1:0]      srch_lv;
    logic [gicdf_pkg::CDF_W-1:0]      srch_hv;
    logic [gicdf_pkg::CDF_W-1:0]      w_calc;
    logic [gicdf_pkg::CDF_W-1:0]      d_calc;
    logic signed [24:0]               p_wide;
    logic [gicdf_pkg::P_W-1:0]        p_abs;
    logic [gicdf_pkg::DEN_W-1:0]      den;
    logic                             div_start;
    gicdf_pkg::div_stat_t             div_stat;
    logic [gicdf_pkg::DVD_W-1:0]      dividend;
    logic [gicdf_pkg::DVD_W-1:0]      quotient;
    logic signed [gicdf_pkg::SUM_W-1:0] q_signed;
    logic signed [gicdf_pkg::SUM_W-1:0] sum;
    logic                             sum_clip;
    logic [31:0]                      sum_sat;
    logic                             out_load;

    // configuration port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (gicdf_pkg::reg_idx_t'(paddr[2]))
            gicdf_pkg::REG_MEAN: prdata = mean_reg;
            gicdf_pkg::REG_STD:  prdata = std_reg;
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= '0;
            std_reg  <= 32'd65536;
        end
        else if (wr_en)
        begin
            unique case (gicdf_pkg::reg_idx_t'(paddr[2]))
                gicdf_pkg::REG_MEAN: mean_reg <= pwdata;
                gicdf_pkg::REG_STD:  std_reg  <= pwdata;
                default:             mean_reg <= mean_reg;
            endcase
        end
    end

    // request side
    assign uniform_ch.ready = (state_reg == S_IDLE) && srch_stat.ready;
    assign accept           = uniform_ch.valid && uniform_ch.ready;

    // scale u by 65536 / (2^B - 1): fold high part onto low part
    assign t_hi    = t_reg >> UNIFORM_BITS;
    assign t_lo    = t_reg & FULL;
    assign xq_next = q_reg + gicdf_pkg::XQ_W'(t_reg == FULL);

    assign srch_start = (state_reg == S_FOLD) && (t_hi == '0);

    gicdf_search u_search (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (srch_start),
        .xq     (xq_next),
        .stat   (srch_stat),
        .lo     (srch_lo),
        .lo_val (srch_lv),
        .hi_val (srch_hv)
    );

    // interpolation numerator
    assign w_calc = srch_hv - srch_lv;
    assign d_calc = xq_reg - srch_lv;
    assign p_wide = (25'(signed'({1'b0, srch_lo})) - 25'(signed'({1'b0, gicdf_pkg::Z_MID})))
                    * signed'(25'(w_calc)) + signed'(25'(d_calc));
    assign p_abs  = p_reg[gicdf_pkg::P_W-1] ? (~p_reg + gicdf_pkg::P_W'(1)) : p_reg;

    assign den       = gicdf_pkg::DEN_W'(w_reg) * gicdf_pkg::DEN_W'(10);
    assign dividend  = {1'b0, mag_reg, 1'b0} + gicdf_pkg::DVD_W'(den);
    assign div_start = (state_reg == S_DSTART);

    gicdf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  ({den, 1'b0}),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // signed offset, add mean, saturate
    always_comb
    begin
        logic signed [gicdf_pkg::SUM_W-1:0] q_mag;
        logic signed [gicdf_pkg::SUM_W-1:0] mean_ext;
        q_mag    = signed'({2'b00, quotient[gicdf_pkg::Q_W-1:0]});
        mean_ext = signed'({{(gicdf_pkg::SUM_W - 32){mean_reg[31]}}, mean_reg});
        q_signed = neg_reg ? -q_mag : q_mag;
        sum      = mean_ext + q_signed;
        sum_clip = !((sum[gicdf_pkg::SUM_W-1:31] == '0)
                     || (sum[gicdf_pkg::SUM_W-1:31] == '1));
        if (!sum_clip)
        begin
            sum_sat = sum[31:0];
        end
        else if (sum[gicdf_pkg::SUM_W-1])
        begin
            sum_sat = 32'h8000_0000;
        end
        else
        begin
            sum_sat = 32'h7FFF_FFFF;
        end
    end

    assign out_load = (state_reg == S_SUM) && (!out_valid_reg || normal_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_FOLD;
            S_FOLD:   if (t_hi == '0) state_next = S_SRCH;
            S_SRCH:   if (srch_stat.done) state_next = S_MUL;
            S_MUL:    state_next = S_DSTART;
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:  if (div_stat.done) state_next = S_SUM;
            S_SUM:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (normal_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg <= T_W'({uniform_ch.uniform_sample, 16'h0000}) + HALF;
            q_reg <= '0;
        end
        else if ((state_reg == S_FOLD) && (t_hi != '0))
        begin
            t_reg <= t_hi + t_lo;
            q_reg <= q_reg + t_hi[gicdf_pkg::XQ_W-1:0];
        end
        if (srch_start)
        begin
            xq_reg <= xq_next;
        end
        if ((state_reg == S_SRCH) && srch_stat.done)
        begin
            w_reg <= w_calc;
            p_reg <= p_wide[gicdf_pkg::P_W-1:0];
        end
        if (state_reg == S_MUL)
        begin
            neg_reg <= p_reg[gicdf_pkg::P_W-1];
            mag_reg <= gicdf_pkg::MAG_W'(p_abs) * gicdf_pkg::MAG_W'(std_reg);
        end
        if (out_load)
        begin
            out_data_reg <= sum_sat;
            out_clip_reg <= sum_clip;
        end
    end

    assign normal_ch.valid         = out_valid_reg;
    assign normal_ch.normal_sample = out_data_reg;
    assign normal_ch.clipped       = out_clip_reg;

    a_accept_starts_fold: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_FOLD)
        else $error("accepted request did not start scaling");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_xq_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        srch_start |-> xq_next <= gicdf_pkg::CDF_TOP)
        else $error("scaled uniform value above one");

    a_div_done_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |=> state_reg == S_SUM)
        else $error("quotient not consumed");

    a_search_done_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        srch_stat.done |-> state_reg == S_SRCH)
        else $error("search finished outside search phase");

endmodule

@@ hw/rtl/gicdf_ram.sv @@
// ----------------------------------------------------------------------------
// gicdf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module gicdf_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 63
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/gicdf_search.sv @@
// ----------------------------------------------------------------------------
// gicdf_search
// Loads the CDF table into RAM after reset, then binary-searches it for the
// interval that brackets the scaled uniform value.
// ----------------------------------------------------------------------------
module gicdf_search (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gicdf_pkg::XQ_W-1:0]   xq,
    output gicdf_pkg::srch_stat_t       stat,
    output logic [gicdf_pkg::ADDR_W-1:0] lo,
    output logic [gicdf_pkg::CDF_W-1:0]  lo_val,
    output logic [gicdf_pkg::CDF_W-1:0]  hi_val
);

    logic                        filling_reg;
    logic [gicdf_pkg::ADDR_W-1:0] fill_cnt_reg;
    logic                        busy_reg;
    logic                        pend_reg;
    logic [gicdf_pkg::ADDR_W-1:0] lo_reg;
    logic [gicdf_pkg::ADDR_W-1:0] hi_reg;
    logic [gicdf_pkg::ADDR_W-1:0] mid_reg;
    logic [gicdf_pkg::CDF_W-1:0]  lv_reg;
    logic [gicdf_pkg::CDF_W-1:0]  hv_reg;
    logic [gicdf_pkg::XQ_W-1:0]   xq_reg;

    logic [gicdf_pkg::ADDR_W:0]   mid_sum;
    logic [gicdf_pkg::ADDR_W-1:0] mid;
    logic                        more;
    logic [gicdf_pkg::CDF_W-1:0]  rdata;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[gicdf_pkg::ADDR_W:1];
    assign more    = (hi_reg - lo_reg) > gicdf_pkg::ADDR_W'(1);

    gicdf_ram #(
        .WIDTH (gicdf_pkg::CDF_W),
        .DEPTH (gicdf_pkg::ROM_DEPTH)
    ) u_cdf_ram (
        .clk   (clk),
        .we    (filling_reg),
        .waddr (fill_cnt_reg),
        .wdata (gicdf_pkg::cdf_value(fill_cnt_reg)),
        .raddr (mid),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filling_reg  <= 1'b1;
            fill_cnt_reg <= '0;
            busy_reg     <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            if (filling_reg)
            begin
                fill_cnt_reg <= fill_cnt_reg + gicdf_pkg::ADDR_W'(1);
                if (fill_cnt_reg == gicdf_pkg::ROM_LAST)
                begin
                    filling_reg <= 1'b0;
                end
            end
            if (start)
            begin
                busy_reg <= 1'b1;
                pend_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (pend_reg)
                begin
                    pend_reg <= 1'b0;
                end
                else if (more)
                begin
                    pend_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_reg <= '0;
            hi_reg <= gicdf_pkg::ROM_LAST;
            lv_reg <= gicdf_pkg::CDF_BOT;
            hv_reg <= gicdf_pkg::CDF_TOP;
            xq_reg <= xq;
        end
        else if (busy_reg && pend_reg)
        begin
            if (xq_reg < rdata)
            begin
                hi_reg <= mid_reg;
                hv_reg <= rdata;
            end
            else
            begin
                lo_reg <= mid_reg;
                lv_reg <= rdata;
            end
        end
        if (busy_reg && !pend_reg)
        begin
            mid_reg <= mid;
        end
    end

    assign stat.ready = !filling_reg;
    assign stat.done  = busy_reg && !pend_reg && !more && !start;
    assign lo         = lo_reg;
    assign lo_val     = lv_reg;
    assign hi_val     = hv_reg;

    a_probe_holds_order: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (lo_reg < hi_reg) && (lv_reg <= hv_reg))
        else $error("search bounds crossed");

    a_no_search_while_fill: assert property (@(posedge clk) disable iff (!rst_n)
        filling_reg |-> !busy_reg)
        else $error("search ran while table loading");

    a_pend_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !pend_reg && more && !start |=> pend_reg)
        else $error("probe read not followed by compare");

endmodule

@@ hw/rtl/gicdf_div.sv @@
// ----------------------------------------------------------------------------
// gicdf_div
// Iterative restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module gicdf_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gicdf_pkg::DVD_W-1:0] dividend,
    input  logic [gicdf_pkg::DVS_W-1:0] divisor,
    output gicdf_pkg::div_stat_t       stat,
    output logic [gicdf_pkg::DVD_W-1:0] quotient
);

    localparam int STEPS = (gicdf_pkg::DVD_W + 1) / 2;
    localparam int SH_W  = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int R_W   = gicdf_pkg::DVS_W;

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SH_W-1:0]  sh_reg;
    logic [R_W-1:0]   rem_reg;
    logic [R_W-1:0]   dvs_reg;

    logic [SH_W-1:0]  sh_next;
    logic [R_W-1:0]   rem_next;

    always_comb
    begin
        logic [R_W:0] trial;
        sh_next  = sh_reg;
        rem_next = rem_reg;
        for (int k = 0; k < 2; k++)
        begin
            trial   = {rem_next, sh_next[SH_W-1]};
            sh_next = {sh_next[SH_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial      = trial - {1'b0, dvs_reg};
                sh_next[0] = 1'b1;
            end
            rem_next = trial[R_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(STEPS - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= SH_W'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == '0);
    assign quotient  = sh_reg[gicdf_pkg::DVD_W-1:0];

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < dvs_reg)
        else $error("partial remainder not reduced");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done && !start |=> !busy_reg)
        else $error("divider kept running after last step");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg < CNT_W'(STEPS))
        else $error("step count out of range");

endmodule
